// ===== rtl/core/spsrch_pkg.sv =====
`timescale 1ns / 1ps

package spsrch_pkg;

    localparam int unsigned NUM_FIRST  = 4;
    localparam int unsigned NUM_SECOND = 16;
    localparam int unsigned FIRST_IW   = $clog2(NUM_FIRST);
    localparam int unsigned SECOND_IW  = $clog2(NUM_SECOND);
    localparam int unsigned BUS_W      = 28;
    localparam int unsigned WANT_W     = 32;
    localparam int unsigned ACT_W      = 27;
    localparam int unsigned PROD_W     = 58;
    localparam int unsigned CMP_W      = 48;

    localparam logic [BUS_W-1:0] BUS_RESET = BUS_W'(48000000);

    // Scaled reciprocals for an exact floor divide of a 28-bit value by 3, 5 and 7.
    // The divide by two is a plain shift and takes no multiplier.
    localparam logic [29:0] FIRST_MAGIC [NUM_FIRST] = '{
        30'd0, 30'd357913942, 30'd429496730, 30'd306783379
    };
    localparam int unsigned FIRST_SHIFT [NUM_FIRST] = '{1, 30, 31, 31};

    // Scaled reciprocals for an exact floor divide of a 28-bit value by six times each
    // prescaler, that is by 12, 18, 30 and 42.
    localparam logic [29:0] SIX_MAGIC [NUM_FIRST] = '{
        30'd357913942, 30'd477218589, 30'd286331154, 30'd409044505
    };
    localparam int unsigned SIX_SHIFT [NUM_FIRST] = '{32, 33, 33, 34};

    // The scaler of six is the one entry that is not a power of two.
    localparam logic [SECOND_IW-1:0] SIX_IDX = SECOND_IW'(2);
    localparam int unsigned SECOND_LOG2 [NUM_SECOND] = '{
        1, 2, 0, 3, 4, 5, 6, 7, 8, 9, 10, 11, 12, 13, 14, 15
    };

    typedef struct packed {
        logic                 valid;
        logic [WANT_W-1:0]    want;
        logic [ACT_W-1:0]     best;
        logic [FIRST_IW-1:0]  best_p;
        logic [SECOND_IW-1:0] best_s;
    } carry_t;

    function automatic logic [BUS_W-1:0] div_first(input logic [BUS_W-1:0] x,
                                                   input logic [FIRST_IW-1:0] idx);
        logic [PROD_W-1:0] prod;
        prod = PROD_W'(x) * PROD_W'(FIRST_MAGIC[idx]);
        if (idx == '0)
            return x >> 1;
        else
            return BUS_W'(prod >> FIRST_SHIFT[idx]);
    endfunction

    function automatic logic [BUS_W-1:0] div_six_first(input logic [BUS_W-1:0] x,
                                                       input logic [FIRST_IW-1:0] idx);
        logic [PROD_W-1:0] prod;
        prod = PROD_W'(x) * PROD_W'(SIX_MAGIC[idx]);
        return BUS_W'(prod >> SIX_SHIFT[idx]);
    endfunction

    // True when scaler j times the request reaches q, that is when the scaler is not
    // below the ceiling of q over the request.
    function automatic logic scaler_fits(input logic [WANT_W-1:0] want,
                                         input logic [BUS_W-1:0] q,
                                         input logic [SECOND_IW-1:0] j);
        logic [CMP_W-1:0] prod;
        if (j == SIX_IDX)
            prod = (CMP_W'(want) << 2) + (CMP_W'(want) << 1);
        else
            prod = CMP_W'(want) << SECOND_LOG2[j];
        return prod >= CMP_W'(q);
    endfunction

endpackage

// ===== rtl/core/spsrch_cell.sv =====
`timescale 1ns / 1ps

module spsrch_cell #(
    parameter int unsigned INDEX = 0
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic [spsrch_pkg::BUS_W-1:0]        bus_hz,
    input  spsrch_pkg::carry_t                  carry_in,
    output spsrch_pkg::carry_t                  carry_out
);

    localparam logic [spsrch_pkg::FIRST_IW-1:0] IDX = spsrch_pkg::FIRST_IW'(INDEX);
    localparam logic [spsrch_pkg::BUS_W-1:0] Q_RESET =
        spsrch_pkg::div_first(spsrch_pkg::BUS_RESET, IDX);
    localparam logic [spsrch_pkg::BUS_W-1:0] Q6_RESET =
        spsrch_pkg::div_six_first(spsrch_pkg::BUS_RESET, IDX);

    // Bus clock over this cell's prescaler, and that quotient over six. Both are registered
    // from the bus clock register and are settled by the time a word reaches this cell.
    logic [spsrch_pkg::BUS_W-1:0] q_reg;
    logic [spsrch_pkg::BUS_W-1:0] q_next;
    logic [spsrch_pkg::BUS_W-1:0] q6_reg;
    logic [spsrch_pkg::BUS_W-1:0] q6_next;

    spsrch_pkg::carry_t out_reg;
    spsrch_pkg::carry_t out_next;

    logic [spsrch_pkg::SECOND_IW-1:0] sel;
    logic                             hit;
    logic [spsrch_pkg::ACT_W-1:0]     freq;

    assign q_next  = spsrch_pkg::div_first(bus_hz, IDX);
    assign q6_next = spsrch_pkg::div_six_first(bus_hz, IDX);

    // Smallest scaler that fits; the scalers rise with the index.
    always_comb
    begin
        sel = '0;
        hit = 1'b0;
        for (int j = spsrch_pkg::NUM_SECOND - 1; j >= 0; j--)
        begin
            if (spsrch_pkg::scaler_fits(carry_in.want, q_reg, spsrch_pkg::SECOND_IW'(j)))
            begin
                sel = spsrch_pkg::SECOND_IW'(j);
                hit = 1'b1;
            end
        end
    end

    // The chosen scaler is never below q over the request, so the frequency cannot
    // exceed the request and needs no further check.
    always_comb
    begin
        if (sel == spsrch_pkg::SIX_IDX)
            freq = spsrch_pkg::ACT_W'(q6_reg);
        else
            freq = spsrch_pkg::ACT_W'(q_reg >> spsrch_pkg::SECOND_LOG2[sel]);
    end

    always_comb
    begin
        out_next = carry_in;
        if (hit && (freq > carry_in.best))
        begin
            out_next.best   = freq;
            out_next.best_p = IDX;
            out_next.best_s = sel;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_reg   <= Q_RESET;
            q6_reg  <= Q6_RESET;
            out_reg <= '0;
        end
        else
        begin
            q_reg   <= q_next;
            q6_reg  <= q6_next;
            out_reg <= out_next;
        end
    end

    assign carry_out = out_reg;

endmodule

// ===== rtl/core/spi_prescaler_search_unit.sv =====
`timescale 1ns / 1ps

// Finds the fastest serial clock, bus clock over a first-stage prescaler (2, 3, 5, 7) and
// a second-stage scaler (2, 4, 6, 8, 16 ... 32768), that does not exceed desired_hz. A word
// is taken at every clock edge where start is high; busy stays low, as nothing in the
// design ever holds a word back. Each word passes one input register and then a row of four
// cells, one per first-stage prescaler, each keeping the best candidate so far as the word
// passes, and gives one result, flagged by done for a single cycle. The receiver cannot
// stall. A request of zero, or one that no pair fits, returns found low with all other
// fields zero. The bus clock register is to be written only while no word is in flight;
// the block does not enforce it. A write applies to words started from the next cycle on.
module spi_prescaler_search_unit (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_wr_en,
    input  logic [spsrch_pkg::BUS_W-1:0]        cfg_wr_data,
    input  logic                                start,
    output logic                                busy,
    input  logic [spsrch_pkg::WANT_W-1:0]       desired_hz,
    output logic                                done,
    output logic                                found,
    output logic [spsrch_pkg::ACT_W-1:0]        actual_hz,
    output logic [spsrch_pkg::FIRST_IW-1:0]     first_stage_index,
    output logic [spsrch_pkg::SECOND_IW-1:0]    second_stage_index
);

    localparam int unsigned LATENCY = spsrch_pkg::NUM_FIRST + 1;

    logic [spsrch_pkg::BUS_W-1:0]  bus_reg;
    logic [spsrch_pkg::BUS_W-1:0]  bus_next;
    logic                          in_valid_reg;
    logic                          in_valid_next;
    logic [spsrch_pkg::WANT_W-1:0] in_want_reg;
    logic                          accept;

    spsrch_pkg::carry_t chain [spsrch_pkg::NUM_FIRST+1];

    assign busy          = 1'b0;
    assign accept        = start && !busy;
    assign bus_next      = cfg_wr_en ? cfg_wr_data : bus_reg;
    assign in_valid_next = accept;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bus_reg      <= spsrch_pkg::BUS_RESET;
            in_valid_reg <= 1'b0;
        end
        else
        begin
            bus_reg      <= bus_next;
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_want_reg <= desired_hz;
        end
    end

    always_comb
    begin
        chain[0].valid  = in_valid_reg;
        chain[0].want   = in_want_reg;
        chain[0].best   = '0;
        chain[0].best_p = '0;
        chain[0].best_s = '0;
    end

    for (genvar i = 0; i < spsrch_pkg::NUM_FIRST; i++)
    begin : g_cell
        spsrch_cell #(
            .INDEX (i)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .bus_hz    (bus_reg),
            .carry_in  (chain[i]),
            .carry_out (chain[i+1])
        );
    end

    assign done               = chain[spsrch_pkg::NUM_FIRST].valid;
    assign found              = chain[spsrch_pkg::NUM_FIRST].best != '0;
    assign actual_hz          = chain[spsrch_pkg::NUM_FIRST].best;
    assign first_stage_index  = chain[spsrch_pkg::NUM_FIRST].best_p;
    assign second_stage_index = chain[spsrch_pkg::NUM_FIRST].best_s;

    a_word_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> ##LATENCY done)
        else $error("accepted word produced no result");

    a_result_has_word: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(accept, LATENCY))
        else $error("result without an accepted word");

    a_found_has_freq: assert property (@(posedge clk) disable iff (!rst_n)
        (done && found) |-> (actual_hz != '0))
        else $error("found result with zero frequency");

    a_miss_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !found) |-> (first_stage_index == '0 && second_stage_index == '0))
        else $error("not-found result carries non-zero indices");

endmodule

// ===== tb/spi_prescaler_search_unit_test.sv =====
`timescale 1ns / 1ps

module spi_prescaler_search_unit_test;

    localparam int unsigned WATCHDOG_LIMIT = 2000;
    localparam int unsigned SETTLE_CYCLES  = 10;

    localparam int unsigned PRESCALE [spsrch_pkg::NUM_FIRST] = '{2, 3, 5, 7};
    localparam int unsigned SCALE [spsrch_pkg::NUM_SECOND] = '{
        2, 4, 6, 8, 16, 32, 64, 128, 256, 512, 1024, 2048, 4096, 8192, 16384, 32768
    };

    typedef struct packed {
        logic                             found;
        logic [spsrch_pkg::ACT_W-1:0]     actual_hz;
        logic [spsrch_pkg::FIRST_IW-1:0]  first_idx;
        logic [spsrch_pkg::SECOND_IW-1:0] second_idx;
    } selection_t;

    logic                             clk = 1'b0;
    logic                             rst_n = 1'b0;
    logic                             cfg_wr_en = 1'b0;
    logic [spsrch_pkg::BUS_W-1:0]     cfg_wr_data = '0;
    logic                             start = 1'b0;
    logic                             busy;
    logic [spsrch_pkg::WANT_W-1:0]    desired_hz = '0;
    logic                             done;
    logic                             found;
    logic [spsrch_pkg::ACT_W-1:0]     actual_hz;
    logic [spsrch_pkg::FIRST_IW-1:0]  first_stage_index;
    logic [spsrch_pkg::SECOND_IW-1:0] second_stage_index;

    selection_t                   pending_selections [$];
    selection_t                   selection_due;
    logic [spsrch_pkg::BUS_W-1:0] bus_clock_shadow = spsrch_pkg::BUS_RESET;
    int                           sender_idle_pct = 0;
    int                           mismatch_count = 0;

    spi_prescaler_search_unit DUT (
        .clk                (clk),
        .rst_n              (rst_n),
        .cfg_wr_en          (cfg_wr_en),
        .cfg_wr_data        (cfg_wr_data),
        .start              (start),
        .busy               (busy),
        .desired_hz         (desired_hz),
        .done               (done),
        .found              (found),
        .actual_hz          (actual_hz),
        .first_stage_index  (first_stage_index),
        .second_stage_index (second_stage_index)
    );

    always #2 clk = ~clk;

    // Fastest pair of prescaler and scaler whose frequency does not exceed the request.
    // The ceiling is taken at 64 bits, so a large request cannot wrap.
    function automatic selection_t best_prescaler_pair(
        input logic [spsrch_pkg::WANT_W-1:0] want,
        input logic [spsrch_pkg::BUS_W-1:0] bus);
        longint unsigned q;
        longint unsigned ceil_q;
        longint unsigned freq;
        longint unsigned best;
        int              j;
        selection_t      sel;
        sel  = '0;
        best = 0;
        if (want != '0)
        begin
            for (int i = 0; i < spsrch_pkg::NUM_FIRST; i++)
            begin
                q = 64'(bus) / PRESCALE[i];
                ceil_q = (q + 64'(want) - 1) / 64'(want);
                j = 0;
                while (j < spsrch_pkg::NUM_SECOND && 64'(SCALE[j]) < ceil_q)
                    j++;
                if (j == spsrch_pkg::NUM_SECOND)
                    continue;
                freq = q / SCALE[j];
                if (freq > 64'(want))
                    continue;
                // Strictly greater, so a tie keeps the earlier prescaler.
                if (freq > best)
                begin
                    best = freq;
                    sel.first_idx = spsrch_pkg::FIRST_IW'(i);
                    sel.second_idx = spsrch_pkg::SECOND_IW'(j);
                end
            end
        end
        if (best == 0)
            sel = '0;
        else
        begin
            sel.found = 1'b1;
            sel.actual_hz = spsrch_pkg::ACT_W'(best);
        end
        return sel;
    endfunction

    function automatic logic [spsrch_pkg::WANT_W-1:0] pick_request(
        input logic [spsrch_pkg::BUS_W-1:0] bus);
        int unsigned near;
        near = (int'(bus) / PRESCALE[$urandom_range(spsrch_pkg::NUM_FIRST - 1)])
               / SCALE[$urandom_range(spsrch_pkg::NUM_SECOND - 1)];
        case ($urandom_range(9))
            0, 1:    return $urandom;
            2:       return $urandom_range(1, 1000);
            3:       return $urandom_range(1, 200000000);
            4:       return near;
            5:       return near + 1;
            6:       return (near == 0) ? 32'd0 : near - 1;
            7:       return (bus >> $urandom_range(1, 27)) + $urandom_range(0, 3);
            8:       return $urandom_range(0, 20) == 0 ? 32'd0 : $urandom_range(1, 70000);
            default: return spsrch_pkg::WANT_W'(bus) >> $urandom_range(0, 16);
        endcase
    endfunction

    function automatic logic [spsrch_pkg::BUS_W-1:0] pick_bus_clock();
        case ($urandom_range(9))
            0:       return 28'd1000000;
            1:       return 28'd200000000;
            2:       return spsrch_pkg::BUS_W'($urandom_range(0, 1000));
            3:       return {spsrch_pkg::BUS_W{1'b1}};
            4:       return spsrch_pkg::BUS_W'($urandom);
            default: return spsrch_pkg::BUS_W'($urandom_range(1000000, 200000000));
        endcase
    endfunction

    task automatic send_request(input logic [spsrch_pkg::WANT_W-1:0] want);
        start <= 1'b1;
        desired_hz <= want;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        pending_selections.push_back(best_prescaler_pair(want, bus_clock_shadow));
        if ($urandom_range(99) < sender_idle_pct)
        begin
            start <= 1'b0;
            desired_hz <= $urandom;
            do
                @(posedge clk);
            while ($urandom_range(99) < sender_idle_pct);
        end
    endtask

    // The register may only change with no word in flight.
    task automatic write_bus_clock(input logic [spsrch_pkg::BUS_W-1:0] value);
        start <= 1'b0;
        do
            @(posedge clk);
        while (pending_selections.size() != 0);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        bus_clock_shadow = value;
    endtask

    task automatic test_request_extremes();
        send_request(32'd0);
        send_request(32'd1);
        send_request(32'hFFFF_FFFF);
        send_request(32'h8000_0000);
        send_request(32'h7FFF_FFFF);
        send_request(32'd24000000);
        send_request(32'd1000000);
        send_request(32'd732);
        send_request(32'd733);
        send_request(32'd100);
    endtask

    task automatic test_bus_clock_corners();
        // Prescalers two and three give the same frequency here.
        write_bus_clock(28'd42);
        send_request(32'd3);
        send_request(32'd21);
        // A bus clock of one only gives zero-hertz candidates.
        write_bus_clock(28'd1);
        send_request(32'd1);
        write_bus_clock(28'd0);
        send_request(32'd5);
        write_bus_clock({spsrch_pkg::BUS_W{1'b1}});
        send_request(32'hFFFF_FFFF);
        send_request(32'd1);
        write_bus_clock(28'd1000000);
        send_request(32'd1);
        send_request(32'd500000);
        write_bus_clock(28'd200000000);
        send_request(32'd100000000);
        send_request(32'd3);
        write_bus_clock(spsrch_pkg::BUS_RESET);
    endtask

    task automatic test_random_phases();
        int idle_pct [4] = '{0, 88, 0, 28};
        for (int phase = 0; phase < 4; phase++)
        begin
            sender_idle_pct = idle_pct[phase];
            for (int chunk = 0; chunk < 4; chunk++)
            begin
                write_bus_clock(pick_bus_clock());
                repeat (122)
                    send_request(pick_request(bus_clock_shadow));
            end
        end
        sender_idle_pct = 0;
    endtask

    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (pending_selections.size() == 0)
            begin
                $error("result word with no request outstanding");
                mismatch_count++;
            end
            else
            begin
                selection_due = pending_selections.pop_front();
                if (found !== selection_due.found)
                begin
                    $error("found: expected %0d, got %0d", selection_due.found, found);
                    mismatch_count++;
                end
                if (actual_hz !== selection_due.actual_hz)
                begin
                    $error("actual_hz: expected %0d, got %0d",
                           selection_due.actual_hz, actual_hz);
                    mismatch_count++;
                end
                if (first_stage_index !== selection_due.first_idx)
                begin
                    $error("first_stage_index: expected %0d, got %0d",
                           selection_due.first_idx, first_stage_index);
                    mismatch_count++;
                end
                if (second_stage_index !== selection_due.second_idx)
                begin
                    $error("second_stage_index: expected %0d, got %0d",
                           selection_due.second_idx, second_stage_index);
                    mismatch_count++;
                end
            end
        end
    end

    // Ends the run with a failure once nothing has been accepted or returned for too long.
    initial
    begin : watchdog
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((start === 1'b1 && busy === 1'b0) || done === 1'b1)
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("FAILURE");
        $finish;
    end

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_request_extremes();
        test_bus_clock_corners();
        test_random_phases();
        start <= 1'b0;
        while (pending_selections.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/core/spsrch_pkg.sv
rtl/core/spsrch_cell.sv
rtl/core/spi_prescaler_search_unit.sv
tb/spi_prescaler_search_unit_test.sv
